[hw/rtl/kmce_pkg.sv]
// Package: shared widths, scan code layout and the request handoff type.
package kmce_pkg;

  localparam int unsigned ColW   = 3;
  localparam int unsigned RowW   = 8;
  localparam int unsigned RowIdW = 3;
  localparam int unsigned CodeW  = 7;
  localparam int unsigned PressBit = 6;

  typedef struct packed {
    logic            vld;
    logic [ColW-1:0] col;
    logic [RowW-1:0] now;
    logic [RowW-1:0] diff;
  } load_t;

endpackage

[hw/rtl/kmce_hist.sv]
// Column history store: holds the last row byte per column and forms the change mask.
module kmce_hist #(
  parameter int unsigned NUM_COLUMNS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [kmce_pkg::ColW-1:0]   column_i,
  input  logic [kmce_pkg::RowW-1:0]   row_levels_i,
  output kmce_pkg::load_t             load_o
);

  localparam int unsigned IdxW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

  logic [kmce_pkg::RowW-1:0] hist_q [NUM_COLUMNS];
  logic [IdxW-1:0]           idx;
  logic                      in_range;

  assign idx      = column_i[IdxW-1:0];
  assign in_range = ({29'd0, column_i} < NUM_COLUMNS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        hist_q[i] <= '1;
      end
    end else if (accept_i && in_range) begin
      hist_q[idx] <= row_levels_i;
    end
  end

  always_comb begin
    load_o.vld  = accept_i && in_range;
    load_o.col  = column_i;
    load_o.now  = row_levels_i;
    load_o.diff = in_range ? (hist_q[idx] ^ row_levels_i) : '0;
  end

endmodule

[hw/rtl/kmce_ser.sv]
// Bit-serial encoder: shifts the change mask one row per cycle unless the output stalls, and registers scan codes.
module kmce_ser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kmce_pkg::load_t              load_i,
  output logic                         busy_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kmce_pkg::CodeW-1:0]   scan_code_o,
  output logic                         pressed_o,
  output logic                         last_o
);

  logic [kmce_pkg::RowW-1:0]   diff_q, diff_d;
  logic [kmce_pkg::RowW-1:0]   now_q, now_d;
  logic [kmce_pkg::RowIdW-1:0] row_q, row_d;
  logic [kmce_pkg::ColW-1:0]   col_q, col_d;
  logic                        out_valid_q, out_valid_d;
  logic [kmce_pkg::CodeW-1:0]  code_q, code_d;
  logic                        pressed_q, pressed_d;
  logic                        last_q, last_d;
  logic                        slot_free, emit, advance, down;

  assign busy_o    = |diff_q;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit      = diff_q[0] && slot_free;
  assign advance   = busy_o && (!diff_q[0] || slot_free);
  assign down      = !now_q[0];

  always_comb begin
    diff_d      = diff_q;
    now_d       = now_q;
    row_d       = row_q;
    col_d       = col_q;
    out_valid_d = slot_free ? 1'b0 : out_valid_q;
    code_d      = code_q;
    pressed_d   = pressed_q;
    last_d      = last_q;
    if (load_i.vld) begin
      diff_d = load_i.diff;
      now_d  = load_i.now;
      col_d  = load_i.col;
      row_d  = '0;
    end else if (advance) begin
      diff_d = diff_q >> 1;
      now_d  = now_q >> 1;
      row_d  = row_q + 3'd1;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      code_d      = {down, col_q, row_q};
      pressed_d   = down;
      last_d      = (diff_q[kmce_pkg::RowW-1:1] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      diff_q      <= diff_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    row_q     <= row_d;
    col_q     <= col_d;
    code_q    <= code_d;
    pressed_q <= pressed_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign scan_code_o = code_q;
  assign pressed_o   = pressed_q;
  assign last_o      = last_q;

endmodule

[hw/rtl/key_matrix_change_encoder_top.sv]
// Top level of the key matrix change encoder.
// Input channel: in_valid_i / in_stall_o carry a column index and its eight
// active-low row levels. Output channel: out_valid_o / out_stall_i carry one
// scan code per changed row, rows in ascending order, with out_last_o on the
// final code of a request. Requests with no change, or a column at or above
// NUM_COLUMNS, produce no output and leave the history untouched (the latter).
// Codes pass from the shift mask into the output register, which drives the outputs.
// The change mask is shifted one row per cycle unless a held output register
// pauses it; a request with no change never raises in_stall_o. One request is
// worked at a time; in_stall_o stays high until every changed row has been
// moved into the output register.
// A stalled receiver holds the output register, which in turn pauses the
// shift at the next changed row; nothing is dropped.
// Reset clears the output valid and the shift mask and sets every column's
// history to all ones, meaning every key released.
module key_matrix_change_encoder_top #(
  parameter int unsigned NUM_COLUMNS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kmce_pkg::ColW-1:0]   in_column_i,
  input  logic [kmce_pkg::RowW-1:0]   in_row_levels_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kmce_pkg::CodeW-1:0]  out_scan_code_o,
  output logic                        out_pressed_o,
  output logic                        out_last_o
);

  kmce_pkg::load_t load;
  logic            accept;
  logic            busy;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  kmce_hist #(
    .NUM_COLUMNS(NUM_COLUMNS)
  ) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .column_i    (in_column_i),
    .row_levels_i(in_row_levels_i),
    .load_o      (load)
  );

  kmce_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .scan_code_o(out_scan_code_o),
    .pressed_o  (out_pressed_o),
    .last_o     (out_last_o)
  );

  a_more_rows_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_last_o) |-> in_stall_o)
    else $error("non-last code shown with no rows pending");

  a_press_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_scan_code_o[kmce_pkg::PressBit] == out_pressed_o))
    else $error("press flag and scan code disagree");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load.vld |-> !busy)
    else $error("new request loaded while shifting");

endmodule

[dv/testbench.sv]
// Testbench for the key matrix change encoder: directed table, then random column samples.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumCols    = 8;
  localparam int unsigned DirN       = 20;
  localparam int unsigned RandN      = 110;
  localparam int unsigned DrainN     = 40;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [kmce_pkg::CodeW-1:0] code;
    logic                       pressed;
    logic                       last;
  } scan_code_t;

  typedef struct packed {
    logic [kmce_pkg::ColW-1:0] col;
    logic [kmce_pkg::RowW-1:0] levels;
    logic                      typed;
    scan_code_t                want;
  } sample_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [kmce_pkg::ColW-1:0]  in_column_i = '0;
  logic [kmce_pkg::RowW-1:0]  in_row_levels_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [kmce_pkg::CodeW-1:0] out_scan_code_o;
  logic                       out_pressed_o;
  logic                       out_last_o;

  logic [kmce_pkg::RowW-1:0] key_history [NumCols];
  scan_code_t      pending_codes [$];
  scan_code_t      got_code;
  bit              idle_on = 1'b1;
  int unsigned     mismatches = 0;
  int unsigned     n_requests = 0;
  int unsigned     n_codes = 0;
  int unsigned     n_presses = 0;
  int unsigned     cycle_count = 0;

  sample_row_t dir_rows [DirN] = '{
    '{3'd0, 8'hFF, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd0, 8'hFE, 1'b1, '{7'd64,  1'b1, 1'b1}},
    '{3'd0, 8'hFF, 1'b1, '{7'd0,   1'b0, 1'b1}},
    '{3'd7, 8'h7F, 1'b1, '{7'd127, 1'b1, 1'b1}},
    '{3'd7, 8'hFF, 1'b1, '{7'd63,  1'b0, 1'b1}},
    '{3'd2, 8'hEF, 1'b1, '{7'd84,  1'b1, 1'b1}},
    '{3'd2, 8'hFF, 1'b1, '{7'd20,  1'b0, 1'b1}},
    '{3'd3, 8'h00, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd3, 8'h00, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd3, 8'hFF, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd5, 8'hAA, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd5, 8'h55, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd5, 8'hFF, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd1, 8'h7E, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd1, 8'hFF, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd4, 8'h0F, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd6, 8'hF0, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd4, 8'hFF, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd6, 8'hFF, 1'b0, '{7'd0,   1'b0, 1'b0}},
    '{3'd6, 8'hFF, 1'b0, '{7'd0,   1'b0, 1'b0}}
  };

  key_matrix_change_encoder_top #(
    .NUM_COLUMNS(NumCols)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_column_i    (in_column_i),
    .in_row_levels_i(in_row_levels_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_scan_code_o(out_scan_code_o),
    .out_pressed_o  (out_pressed_o),
    .out_last_o     (out_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic track_sample(input logic [kmce_pkg::ColW-1:0] col,
                              input logic [kmce_pkg::RowW-1:0] levels,
                              input bit queue_codes);
    logic [kmce_pkg::RowW-1:0] diff;
    int              top_row;
    scan_code_t      sc;
    if (col >= NumCols) return;
    diff = key_history[col] ^ levels;
    top_row = -1;
    for (int r = 0; r < kmce_pkg::RowW; r++) if (diff[r]) top_row = r;
    for (int r = 0; r < kmce_pkg::RowW; r++) begin
      if (diff[r]) begin
        sc.code = kmce_pkg::CodeW'((int'(col) << 3) | r);
        sc.pressed = ~levels[r];
        sc.code[kmce_pkg::PressBit] = sc.pressed;
        sc.last = (r == top_row);
        if (queue_codes) pending_codes.push_back(sc);
      end
    end
    key_history[col] = levels;
  endtask

  task automatic send_request(input logic [kmce_pkg::ColW-1:0] col,
                              input logic [kmce_pkg::RowW-1:0] levels,
                              input bit typed, input scan_code_t want);
    while (idle_on && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_column_i     <= col;
    in_row_levels_i <= levels;
    do @(posedge clk_i); while (in_stall_o);
    n_requests++;
    track_sample(col, levels, !typed);
    if (typed) pending_codes.push_back(want);
  endtask

  task automatic wait_for_codes();
    while (pending_codes.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 18);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d codes pending", cycle_count,
               pending_codes.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_codes.size() == 0) begin
        report_mismatch("scan code with none pending", out_scan_code_o, -1);
      end else begin
        got_code = pending_codes.pop_front();
        if (out_scan_code_o !== got_code.code)
          report_mismatch("scan_code", out_scan_code_o, got_code.code);
        if (out_pressed_o !== got_code.pressed)
          report_mismatch("pressed", out_pressed_o, got_code.pressed);
        if (out_last_o !== got_code.last)
          report_mismatch("last", out_last_o, got_code.last);
        n_codes++;
        if (got_code.pressed) n_presses++;
      end
    end
  end

  initial begin
    logic [kmce_pkg::ColW-1:0] col;
    logic [kmce_pkg::RowW-1:0] levels;
    int unsigned     pick;
    for (int c = 0; c < NumCols; c++) key_history[c] = '1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirN; i++)
      send_request(dir_rows[i].col, dir_rows[i].levels, dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < RandN; i++) begin
      idle_on = !(i >= 50 && i < 90);
      if (i == 100) begin
        in_valid_i <= 1'b0;
        wait_for_codes();
        @(posedge clk_i);
      end
      col  = kmce_pkg::ColW'($urandom_range(NumCols - 1));
      pick = $urandom_range(99);
      if (pick < 50)
        levels = key_history[col] ^
                 kmce_pkg::RowW'(1 << $urandom_range(kmce_pkg::RowW - 1));
      else if (pick < 65)
        levels = key_history[col] ^
                 kmce_pkg::RowW'($urandom_range(255) & $urandom_range(255));
      else if (pick < 75)
        levels = key_history[col];
      else
        levels = kmce_pkg::RowW'($urandom_range(255));
      send_request(col, levels, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    idle_on = 1'b1;

    wait_for_codes();
    repeat (DrainN) @(posedge clk_i);
    if (pending_codes.size() != 0)
      report_mismatch("codes left pending", pending_codes.size(), 0);

    $display("%0d column samples sent, %0d scan codes checked (%0d presses, %0d releases)",
             n_requests, n_codes, n_presses, n_codes - n_presses);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
